[design/stq_pkg.sv]
package stq_pkg;

    localparam int TIME_W  = 31;
    localparam int DELTA_W = 30;
    localparam int SLOT_W  = 4;
    localparam int MS_W    = 32;

    typedef enum logic [1:0] {
        FUNC_ARM   = 2'd0,
        FUNC_TICK  = 2'd1,
        FUNC_PAUSE = 2'd2,
        FUNC_CLEAR = 2'd3
    } t_func;

    typedef struct packed {
        logic [1:0]         func;
        logic [TIME_W-1:0]  now_ms;
        logic [SLOT_W-1:0]  slot;
        logic [DELTA_W-1:0] first_delay_ms;
        logic [DELTA_W-1:0] period_ms;
        logic               periodic;
        logic               python_callback;
        logic               pause_value;
        logic               catchup_invoke;
    } t_in_beat;

    typedef struct packed {
        logic              fired;
        logic [SLOT_W-1:0] fired_slot;
        logic              fired_python;
        logic              invoked;
        logic              last;
        logic              truncated;
        logic [MS_W-1:0]   ms_to_next;
    } t_out_beat;

    // Candidate passed along the cell chain during a minimum search.
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] idx;
        logic [TIME_W-1:0] expiry;
        logic              python;
    } t_cand;

    // Command broadcast from the sequencer to every cell.
    typedef struct packed {
        logic               arm;
        logic [SLOT_W-1:0]  arm_slot;
        logic [TIME_W-1:0]  arm_expiry;
        logic [DELTA_W-1:0] arm_period;
        logic               arm_periodic;
        logic               arm_python;
        logic               clear;
        logic               fire;
        logic [SLOT_W-1:0]  fire_slot;
    } t_cell_cmd;

    // Signed wrapping difference a - b, in -2^30 .. 2^30-1.
    function automatic logic signed [TIME_W-1:0] wrap_diff(
        input logic [TIME_W-1:0] a,
        input logic [TIME_W-1:0] b
    );
        wrap_diff = $signed(a - b);
    endfunction

endpackage

[design/stq_cell.sv]
module stq_cell
    import stq_pkg::*;
#(
    parameter logic [SLOT_W-1:0] IDX = '0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  t_cand     i_cand,
    output t_cand     o_cand
);

    logic               r_armed;
    logic [TIME_W-1:0]  r_expiry;
    logic [DELTA_W-1:0] r_period;
    logic               r_periodic;
    logic               r_python;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
        end else if (i_cmd.clear) begin
            r_armed <= 1'b0;
        end else if (i_cmd.arm && i_cmd.arm_slot == IDX) begin
            r_armed    <= 1'b1;
            r_expiry   <= i_cmd.arm_expiry;
            r_period   <= i_cmd.arm_period;
            r_periodic <= i_cmd.arm_periodic;
            r_python   <= i_cmd.arm_python;
        end else if (i_cmd.fire && i_cmd.fire_slot == IDX) begin
            if (r_periodic) begin
                r_expiry <= r_expiry + TIME_W'(r_period);
            end else begin
                r_armed <= 1'b0;
            end
        end
    end

    // Keep the incoming pick unless this slot is armed and either nothing was found yet or it is strictly earlier.
    always_comb begin
        o_cand = i_cand;
        if (r_armed && (!i_cand.found || wrap_diff(r_expiry, i_cand.expiry) < 0)) begin
            o_cand.found  = 1'b1;
            o_cand.idx    = IDX;
            o_cand.expiry = r_expiry;
            o_cand.python = r_python;
        end
    end

endmodule

[design/stq_chain.sv]
module stq_chain
    import stq_pkg::*;
#(
    parameter int NUM_TIMERS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    output t_cand     o_cand
);

    localparam int GRP = 4;
    localparam int NG  = (NUM_TIMERS + GRP - 1) / GRP;

    // Cells are grouped by four; a register after each group breaks the
    // comparison chain, so a search result passes through the register of every group in turn.
    t_cand w_link [NUM_TIMERS+1];
    t_cand r_pipe [NG];

    assign w_link[0] = '0;

    for (genvar g = 0; g < NG; g++) begin : g_grp
        t_cand w_head;
        if (g == 0) begin : g_first
            assign w_head = '0;
        end else begin : g_rest
            assign w_head = r_pipe[g-1];
        end
        for (genvar k = 0; k < GRP; k++) begin : g_cell
            localparam int I = g * GRP + k;
            if (I < NUM_TIMERS) begin : g_on
                t_cand w_in;
                if (k == 0) begin : g_k0
                    assign w_in = w_head;
                end else begin : g_kn
                    assign w_in = w_link[I];
                end
                stq_cell #(.IDX(SLOT_W'(I))) u_cell (
                    .i_clk  (i_clk),
                    .i_rst_n(i_rst_n),
                    .i_cmd  (i_cmd),
                    .i_cand (w_in),
                    .o_cand (w_link[I+1])
                );
            end
        end
        localparam int LAST = ((g + 1) * GRP < NUM_TIMERS) ? (g + 1) * GRP : NUM_TIMERS;
        always_ff @(posedge i_clk) begin
            r_pipe[g] <= w_link[LAST];
        end
    end

    assign o_cand = r_pipe[NG-1];

endmodule

[design/software_timer_queue.sv]
// Channel | Direction | Handshake           | Payload
// input   | in        | i_valid / o_stall   | i_in  (t_in_beat)
// output  | out       | o_valid / i_stall   | o_out (t_out_beat)
//
// An item passes the command, search and decide states from acceptance to the decision
// on its first beat; each firing repeats the search through the chain of NG slot groups of four.
// Reset is synchronous and active low; it disarms every slot and clears pause.
// A stalled output beat holds; the block waits for it before continuing, and the
// input stays stalled until the item's last beat has left the output register.
module software_timer_queue
    import stq_pkg::*;
#(
    parameter int NUM_TIMERS = 16,
    parameter int MAX_FIRES  = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_beat  i_in,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_out
);

    localparam int NG    = (NUM_TIMERS + 3) / 4;
    localparam int WAITW = $clog2(NG + 2);
    localparam int FCW   = $clog2(MAX_FIRES + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_SEARCH,
        ST_DECIDE
    } t_state;

    t_state            r_state;
    t_in_beat          r_item;
    logic              r_paused;
    logic              r_invoke;
    logic              r_run;
    logic [WAITW-1:0]  r_wait;
    logic [FCW-1:0]    r_fires;
    t_cell_cmd         r_cmd;
    t_cand             w_cand;
    t_out_beat         r_out;
    logic              r_ovalid;
    // A firing waits in r_hold until the next search decides whether it was last.
    t_out_beat         r_hold;
    logic              r_have_hold;

    stq_chain #(.NUM_TIMERS(NUM_TIMERS)) u_chain (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (r_cmd),
        .o_cand (w_cand)
    );

    logic signed [TIME_W-1:0] w_dt;
    logic                     w_due;
    logic [MS_W-1:0]          w_ms;

    assign w_dt  = wrap_diff(w_cand.expiry, r_item.now_ms);
    assign w_due = w_cand.found && w_dt <= 0;
    assign w_ms  = !w_cand.found ? '1 : (w_dt <= 0 ? '0 : MS_W'(unsigned'(w_dt)));

    assign o_stall = (r_state != ST_IDLE) || r_ovalid;
    assign o_valid = r_ovalid;
    assign o_out   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_paused    <= 1'b0;
            r_ovalid    <= 1'b0;
            r_have_hold <= 1'b0;
            r_cmd       <= '0;
            r_wait      <= '0;
            r_fires     <= '0;
            r_run       <= 1'b0;
            r_invoke    <= 1'b0;
        end else begin
            r_cmd.arm   <= 1'b0;
            r_cmd.clear <= 1'b0;
            r_cmd.fire  <= 1'b0;
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_item  <= i_in;
                        r_fires <= '0;
                        r_state <= ST_CMD;
                    end
                end
                ST_CMD: begin
                    r_run <= 1'b0;
                    case (t_func'(r_item.func))
                        FUNC_ARM: begin
                            if (32'(r_item.slot) < NUM_TIMERS) begin
                                r_cmd.arm      <= 1'b1;
                                r_cmd.arm_slot <= r_item.slot;
                                r_cmd.arm_expiry <= r_item.now_ms
                                    + TIME_W'(r_item.first_delay_ms);
                                r_cmd.arm_period <= (r_item.period_ms == '0)
                                    ? DELTA_W'(1) : r_item.period_ms;
                                r_cmd.arm_periodic <= r_item.periodic;
                                r_cmd.arm_python   <= r_item.python_callback;
                            end
                        end
                        FUNC_TICK: begin
                            r_run    <= !r_paused;
                            r_invoke <= 1'b1;
                        end
                        FUNC_PAUSE: begin
                            r_run    <= r_paused && !r_item.pause_value;
                            r_invoke <= r_item.catchup_invoke;
                            r_paused <= r_item.pause_value;
                        end
                        FUNC_CLEAR: begin
                            r_cmd.clear <= 1'b1;
                            r_paused    <= 1'b0;
                        end
                        default: ;
                    endcase
                    r_wait  <= WAITW'(NG + 1);
                    r_state <= ST_SEARCH;
                end
                ST_SEARCH: begin
                    if (r_wait == '0) begin
                        r_state <= ST_DECIDE;
                    end else begin
                        r_wait <= r_wait - 1'b1;
                    end
                end
                ST_DECIDE: begin
                    if (!r_ovalid || !i_stall) begin
                        if (r_run && w_due && 32'(r_fires) < MAX_FIRES) begin
                            if (r_have_hold) begin
                                r_out    <= r_hold;
                                r_ovalid <= 1'b1;
                            end
                            r_hold.fired        <= 1'b1;
                            r_hold.fired_slot   <= w_cand.idx;
                            r_hold.fired_python <= w_cand.python;
                            r_hold.invoked      <= r_invoke;
                            r_hold.last         <= 1'b0;
                            r_hold.truncated    <= 1'b0;
                            r_hold.ms_to_next   <= '0;
                            r_have_hold         <= 1'b1;
                            r_fires             <= r_fires + 1'b1;
                            r_cmd.fire          <= 1'b1;
                            r_cmd.fire_slot     <= w_cand.idx;
                            r_wait              <= WAITW'(NG + 1);
                            r_state             <= ST_SEARCH;
                        end else begin
                            if (r_have_hold) begin
                                r_out <= r_hold;
                            end else begin
                                r_out <= '0;
                            end
                            r_out.last       <= 1'b1;
                            r_out.truncated  <= r_run && w_due;
                            r_out.ms_to_next <= w_ms;
                            r_ovalid         <= 1'b1;
                            r_have_hold      <= 1'b0;
                            r_state          <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

[design/stq_checker.sv]
module stq_checker
    import stq_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_stall,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_beat o_out
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out))
        else $error("output beat changed while stalled");

    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out.fired |-> o_out.last)
        else $error("non-firing beat not last");

    a_trunc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.truncated |-> o_out.last && o_out.fired)
        else $error("truncated on wrong beat");

    a_ms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out.last |-> o_out.ms_to_next == '0)
        else $error("ms_to_next on inner beat");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while a result beat waits");

endmodule

bind software_timer_queue stq_checker u_stq_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .o_stall(o_stall),
    .o_valid(o_valid),
    .i_stall(i_stall),
    .o_out  (o_out)
);
